[rtl/core/aesctr_pkg.sv]
`default_nettype none
package aesctr_pkg;

  typedef logic [127:0] blk_t;

  localparam logic [2:0] CFG_KEY_W0 = 3'd0;
  localparam logic [2:0] CFG_KEY_W1 = 3'd1;
  localparam logic [2:0] CFG_KEY_W2 = 3'd2;
  localparam logic [2:0] CFG_KEY_W3 = 3'd3;
  localparam logic [2:0] CFG_KEY_SIZE = 3'd4;
  localparam logic [2:0] CFG_CNT_BYTES = 3'd5;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // low n bytes of a 128-bit value
  function automatic blk_t low_mask(input logic [4:0] n);
    blk_t m;
    m = '0;
    for (int i = 0; i < 16; i++) begin
      if (5'(i) < n) m[8*i +: 8] = 8'hff;
    end
    low_mask = m;
  endfunction

  // first n bytes from byte 0 (msb side)
  function automatic blk_t lead_mask(input logic [4:0] n);
    blk_t m;
    m = '0;
    for (int i = 0; i < 16; i++) begin
      if (5'(i) < n) m[127-8*i -: 8] = 8'hff;
    end
    lead_mask = m;
  endfunction

endpackage
`default_nettype wire

[rtl/core/aesctr_keyexp.sv]
`default_nettype none
module aesctr_keyexp (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [255:0] key,
  input  wire logic [1:0]  key_size,
  input  wire logic [3:0]  rd_round,
  output logic [127:0]     rd_key,
  output logic             busy,
  output logic [3:0]       rounds
);
  import aesctr_pkg::*;

  logic [127:0] mem [15];
  logic [255:0] win;
  logic [5:0] idx;
  logic [5:0] total;
  logic [2:0] nk;
  logic [2:0] pos;
  logic [7:0] rc;
  logic [31:0] t, nw;

  always_comb begin
    t = win[31:0];
    if (pos == 3'd0) begin
      t = sub_word({t[23:0], t[31:24]}) ^ {rc, 24'd0};
    end else if (nk == 3'd0 && pos == 3'd4) begin
      t = sub_word(t);
    end
    unique case (nk)
      3'd4: nw = win[127:96] ^ t;
      3'd6: nw = win[191:160] ^ t;
      default: nw = win[255:224] ^ t;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rounds <= 4'd10;
      nk <= 3'd4;
      pos <= 3'd0;
    end else if (start) begin
      busy <= 1'b1;
      unique case (key_size)
        2'd0: begin
          nk <= 3'd4; rounds <= 4'd10; total <= 6'd44; idx <= 6'd4; pos <= 3'd0;
          win <= {128'd0, key[255:128]};
        end
        2'd1: begin
          nk <= 3'd6; rounds <= 4'd12; total <= 6'd52; idx <= 6'd6; pos <= 3'd0;
          win <= {64'd0, key[255:64]};
        end
        default: begin
          nk <= 3'd0; rounds <= 4'd14; total <= 6'd60; idx <= 6'd8; pos <= 3'd0;
          win <= key;
        end
      endcase
      rc <= 8'h01;
    end else if (busy) begin
      win <= {win[223:0], nw};
      idx <= idx + 6'd1;
      if (pos == 3'd0) rc <= xtime(rc);
      if ((nk == 3'd4 && pos == 3'd3) || (nk == 3'd6 && pos == 3'd5) || pos == 3'd7)
        pos <= 3'd0;
      else
        pos <= pos + 3'd1;
      if (idx == total - 6'd1) busy <= 1'b0;
    end
  end

  // nk code 0 stands for eight words
  always_ff @(posedge clk) begin
    if (start) begin
      mem[0] <= key[255:128];
      if (key_size != 2'd0) mem[1][127:64] <= key[127:64];
      if (key_size[1]) mem[1][63:0] <= key[63:0];
    end else if (busy) begin
      mem[idx[5:2]][{~idx[1:0], 5'd0} +: 32] <= nw;
    end
  end

  always_ff @(posedge clk) begin
    rd_key <= mem[rd_round];
  end

  property p_done;
    @(posedge clk) disable iff (rst) busy && !start && idx == total - 6'd1 |=> !busy;
  endproperty
  a_done: assert property (p_done) else $error("key expansion overrun");
  a_idx: assert property (@(posedge clk) disable iff (rst) busy |-> idx < 6'd60)
    else $error("key index out of range");
  a_rnd: assert property (@(posedge clk) disable iff (rst)
    rounds == 4'd10 || rounds == 4'd12 || rounds == 4'd14) else $error("bad rounds");
endmodule
`default_nettype wire

[rtl/core/aesctr_round.sv]
`default_nettype none
module aesctr_round (
  input  wire logic [127:0] s,
  input  wire logic [127:0] rk,
  input  wire logic         last,
  output logic [127:0]      q
);
  import aesctr_pkg::*;

  logic [7:0] b [16];
  logic [7:0] t [16];
  logic [7:0] a0, a1, a2, a3, al;

  always_comb begin
    for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++)
        t[4*c+i] = SBOX[b[4*((c+i)%4)+i]];
    q = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      if (last) begin
        q[127-32*c -: 32] = {a0, a1, a2, a3};
      end else begin
        q[127-32*c -: 32] = {a0 ^ al ^ xtime(a0 ^ a1), a1 ^ al ^ xtime(a1 ^ a2),
                             a2 ^ al ^ xtime(a2 ^ a3), a3 ^ al ^ xtime(a3 ^ a0)};
      end
    end
    q = q ^ rk;
  end
endmodule
`default_nettype wire

[rtl/core/aes_counter_mode_cipher.sv]
// aes counter-mode engine
// in channel: in_valid/in_stall with mode, word_hi, word_lo, byte_count, finalize
// out channel: out_valid/out_stall with data, valid_bytes and counter fields
// cfg channel: cfg_valid/cfg_ready, cfg_index selects key_w0..3, key_size, counter_bytes
// a start transaction loads the counter and expands round keys, one key word a cycle
// a data transaction runs the aes rounds one at a time on a shared round unit,
// with a wait state before each round, as the round key read is registered
// one transaction is in the core at a time; in_stall is high while it runs and
// a new one is taken from the cycle after its result is registered
// a finished result sits in the output register, so the next transaction can
// start while it waits; with out_stall high the result holds and a second
// finished transaction waits in the core
// reset clears counter, key size 128, counter_bytes 16 and out_valid;
// round keys are undefined until the first start transaction
`default_nettype none
module aes_counter_mode_cipher (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        mode,
  input  wire logic [63:0] word_hi,
  input  wire logic [63:0] word_lo,
  input  wire logic [4:0]  byte_count,
  input  wire logic        finalize,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      data_hi,
  output logic [63:0]      data_lo,
  output logic [4:0]       valid_bytes,
  output logic [63:0]      counter_hi,
  output logic [63:0]      counter_lo,
  output logic             counter_valid
);
  import aesctr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001, ST_KEY = 4'b0010, ST_RUN = 4'b0100, ST_OUT = 4'b1000
  } state_t;

  state_t state;
  logic [255:0] key;
  logic [1:0] key_size;
  logic [4:0] cnt_bytes;
  logic [4:0] cb;
  blk_t ctr, st, din;
  logic [4:0] cnt;
  logic fin;
  logic [3:0] rnd;
  logic kx_start, kx_busy;
  logic [3:0] kx_rounds;
  logic [127:0] rk, rq;
  logic [1:0] pre;
  logic acc;
  logic done;

  assign cfg_ready = 1'b1;
  assign acc = in_valid && !in_stall;
  assign in_stall = state != ST_IDLE;
  assign cb = cnt_bytes > 5'd16 ? 5'd16 : cnt_bytes;
  assign kx_start = acc && !mode;
  assign done = ((state == ST_KEY && !kx_busy) || state == ST_OUT) &&
                (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0; key_size <= 2'd0; cnt_bytes <= 5'd16;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_KEY_W0: key[255:192] <= cfg_data;
        CFG_KEY_W1: key[191:128] <= cfg_data;
        CFG_KEY_W2: key[127:64] <= cfg_data;
        CFG_KEY_W3: key[63:0] <= cfg_data;
        CFG_KEY_SIZE: key_size <= cfg_data[1:0];
        CFG_CNT_BYTES: cnt_bytes <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  aesctr_keyexp u_kx (
    .clk(clk), .rst(rst), .start(kx_start), .key(key), .key_size(key_size),
    .rd_round(rnd), .rd_key(rk), .busy(kx_busy), .rounds(kx_rounds)
  );

  aesctr_round u_rnd (.s(st), .rk(rk), .last(rnd == kx_rounds), .q(rq));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; out_valid <= 1'b0; ctr <= '0;
    end else begin
      if (done) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (acc) begin
            din <= {word_hi, word_lo};
            cnt <= byte_count > 5'd16 ? 5'd16 : byte_count;
            fin <= finalize;
            rnd <= 4'd0; pre <= 2'd0;
            if (!mode) begin
              ctr <= {word_hi, word_lo} & low_mask(cb);
              state <= ST_KEY;
            end else begin
              state <= ST_RUN;
            end
          end
        end
        ST_KEY: begin
          if (done) begin
            data_hi <= '0; data_lo <= '0; valid_bytes <= '0;
            {counter_hi, counter_lo} <= fin ? ctr & low_mask(cb) : '0;
            counter_valid <= fin;
            state <= ST_IDLE;
          end
        end
        ST_RUN: begin
          // pre 0 waits read of round 0 key, 1 applies it
          if (pre == 2'd0) begin
            pre <= 2'd1; rnd <= 4'd0;
          end else if (pre == 2'd1) begin
            st <= ctr ^ rk; rnd <= 4'd1; pre <= 2'd2;
          end else if (pre == 2'd2) begin
            pre <= 2'd3;
          end else begin
            st <= rq; pre <= 2'd2;
            if (rnd == kx_rounds) begin
              state <= ST_OUT;
            end else begin
              rnd <= rnd + 4'd1;
            end
          end
        end
        ST_OUT: begin
          if (done) begin
            {data_hi, data_lo} <= (din ^ st) & lead_mask(cnt);
            valid_bytes <= cnt;
            if (cnt == 5'd16) begin
              ctr <= ctr + 128'd1;
              {counter_hi, counter_lo} <= fin ? (ctr + 128'd1) & low_mask(cb) : '0;
            end else begin
              {counter_hi, counter_lo} <= fin ? ctr & low_mask(cb) : '0;
            end
            counter_valid <= fin;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_run: assert property (@(posedge clk) disable iff (rst) state == ST_RUN |-> !kx_busy)
    else $error("round run during key expansion");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data_hi) && $stable(counter_lo))
    else $error("stalled result changed");
  a_vb: assert property (@(posedge clk) disable iff (rst) out_valid |-> valid_bytes <= 5'd16)
    else $error("valid_bytes too big");
endmodule
`default_nettype wire

[bench/tb_aes_counter_mode_cipher.sv]
`timescale 1ns / 1ps

module tb_aes_counter_mode_cipher;
  import aesctr_pkg::*;

  typedef struct {
    logic [127:0] data;
    logic [4:0]   nbytes;
    logic [127:0] ctr;
    logic         ctr_valid;
  } ctr_result_t;

  class ctr_scoreboard;
    logic [63:0]  key_regs [4];
    logic [1:0]   key_len;
    logic [4:0]   ctr_bytes;
    logic [127:0] ctr;
    logic [31:0]  sched [60];
    int           nrounds;
    ctr_result_t  pending_q [$];
    int           errors;

    function new();
      foreach (key_regs[i]) key_regs[i] = '0;
      foreach (sched[i]) sched[i] = '0;
      key_len = 0;
      ctr_bytes = 16;
      ctr = '0;
      nrounds = 10;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] val);
      case (idx)
        CFG_KEY_W0: key_regs[0] = val;
        CFG_KEY_W1: key_regs[1] = val;
        CFG_KEY_W2: key_regs[2] = val;
        CFG_KEY_W3: key_regs[3] = val;
        CFG_KEY_SIZE: key_len = val[1:0];
        CFG_CNT_BYTES: ctr_bytes = val[4:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] sbox_word(logic [31:0] w);
      return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function logic [7:0] dbl(logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function void expand();
      int nk;
      int total;
      logic [31:0] t;
      logic [7:0] rc;
      nk = (key_len == 0) ? 4 : (key_len == 1) ? 6 : 8;
      nrounds = nk + 6;
      total = 4 * (nrounds + 1);
      for (int i = 0; i < nk; i++)
        sched[i] = i[0] ? key_regs[i >> 1][31:0] : key_regs[i >> 1][63:32];
      rc = 8'h01;
      for (int i = nk; i < total; i++) begin
        t = sched[i - 1];
        if (i % nk == 0) begin
          t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
          rc = dbl(rc);
        end else if (nk > 6 && i % nk == 4) begin
          t = sbox_word(t);
        end
        sched[i] = sched[i - nk] ^ t;
      end
    endfunction

    function logic [127:0] rkey(int r);
      return {sched[(4*r) % 60], sched[(4*r+1) % 60], sched[(4*r+2) % 60],
              sched[(4*r+3) % 60]};
    endfunction

    function logic [127:0] encrypt(logic [127:0] blk);
      logic [127:0] s;
      logic [127:0] t;
      logic [7:0] a0, a1, a2, a3, all;
      s = blk ^ rkey(0);
      for (int r = 1; r <= nrounds; r++) begin
        for (int c = 0; c < 4; c++)
          for (int i = 0; i < 4; i++)
            t[127 - 8*(4*c+i) -: 8] = SBOX[s[127 - 8*(4*((c+i) & 3) + i) -: 8]];
        if (r != nrounds) begin
          for (int c = 0; c < 4; c++) begin
            a0 = t[127 - 32*c -: 8];
            a1 = t[119 - 32*c -: 8];
            a2 = t[111 - 32*c -: 8];
            a3 = t[103 - 32*c -: 8];
            all = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 32*c -: 8] = a0 ^ all ^ dbl(a0 ^ a1);
            t[119 - 32*c -: 8] = a1 ^ all ^ dbl(a1 ^ a2);
            t[111 - 32*c -: 8] = a2 ^ all ^ dbl(a2 ^ a3);
            t[103 - 32*c -: 8] = a3 ^ all ^ dbl(a3 ^ a0);
          end
        end
        s = t ^ rkey(r);
      end
      return s;
    endfunction

    function void note(logic md, logic [127:0] blk, logic [4:0] bc, logic fin);
      ctr_result_t e;
      int cb;
      int n;
      logic [127:0] keep;
      cb = (ctr_bytes > 16) ? 16 : ctr_bytes;
      n = (bc > 16) ? 16 : bc;
      keep = ~({128{1'b1}} << (8*cb));
      e.data = '0;
      e.nbytes = '0;
      if (md == 1'b0) begin
        ctr = blk & keep;
        expand();
      end else begin
        e.nbytes = 5'(n);
        e.data = (blk ^ encrypt(ctr)) & ~({128{1'b1}} >> (8*n));
        if (n == 16) ctr = ctr + 128'd1;
      end
      e.ctr_valid = fin;
      e.ctr = fin ? (ctr & keep) : '0;
      pending_q.push_back(e);
    endfunction

    task report(string what, logic [127:0] got, logic [127:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
      errors++;
    endtask

    task check(logic [127:0] d, logic [4:0] nb, logic [127:0] c, logic cv);
      ctr_result_t e;
      if (pending_q.size() == 0) begin
        report("unexpected transaction", d, '0);
        return;
      end
      e = pending_q.pop_front();
      if (d !== e.data) report("data", d, e.data);
      if (nb !== e.nbytes) report("valid_bytes", 128'(nb), 128'(e.nbytes));
      if (c !== e.ctr) report("counter", c, e.ctr);
      if (cv !== e.ctr_valid) report("counter_valid", 128'(cv), 128'(e.ctr_valid));
    endtask
  endclass

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_DATA = 1'b1;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic mode = 0;
  logic [63:0] word_hi = '0;
  logic [63:0] word_lo = '0;
  logic [4:0] byte_count = '0;
  logic finalize = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [63:0] data_hi, data_lo, counter_hi, counter_lo;
  logic [4:0] valid_bytes;
  logic counter_valid;

  ctr_scoreboard sb = new();
  int send_idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  aes_counter_mode_cipher i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .word_hi(word_hi),
    .word_lo(word_lo), .byte_count(byte_count), .finalize(finalize),
    .out_valid(out_valid), .out_stall(out_stall), .data_hi(data_hi), .data_lo(data_lo),
    .valid_bytes(valid_bytes), .counter_hi(counter_hi), .counter_lo(counter_lo),
    .counter_valid(counter_valid)
  );

  always #6 clk = ~clk;

  always @(negedge clk) out_stall = ($urandom_range(0, 99) < stall_pct);

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note(mode, {word_hi, word_lo}, byte_count, finalize);
      if (out_valid && !out_stall)
        sb.check({data_hi, data_lo}, valid_bytes, {counter_hi, counter_lo}, counter_valid);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("[aes_counter_mode_cipher] ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic setup(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2, logic [63:0] k3,
                       logic [1:0] ks, logic [4:0] cb);
    drain();
    write_reg(CFG_KEY_W0, k0);
    write_reg(CFG_KEY_W1, k1);
    write_reg(CFG_KEY_W2, k2);
    write_reg(CFG_KEY_W3, k3);
    write_reg(CFG_KEY_SIZE, 64'(ks));
    write_reg(CFG_CNT_BYTES, 64'(cb));
  endtask

  task automatic send(logic md, logic [63:0] hi, logic [63:0] lo, logic [4:0] bc, logic fin);
    while ($urandom_range(0, 99) < send_idle_pct) @(negedge clk);
    in_valid = 1;
    mode = md;
    word_hi = hi;
    word_lo = lo;
    byte_count = bc;
    finalize = fin;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 0;
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [4:0] rnd_count();
    return ($urandom_range(0, 1) == 1) ? 5'd16 : 5'($urandom_range(0, 31));
  endfunction

  initial begin
    logic [4:0] cb;
    logic [4:0] counts [8];
    counts = '{5'd16, 5'd0, 5'd1, 5'd8, 5'd9, 5'd15, 5'd31, 5'd17};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: extremes, partial blocks, oversized counts, counter wrap
    setup('1, '1, '1, '1, 2'd2, 5'd16);
    send(MODE_START, '1, '1, 5'd0, 1);
    foreach (counts[i])
      send(MODE_DATA, '1, '1, counts[i], 1);
    send(MODE_DATA, '0, '0, 5'd16, 0);
    send(MODE_START, '1, '1, 5'd31, 1);
    setup('0, '0, '0, '0, 2'd3, 5'd0);
    send(MODE_START, rnd64(), rnd64(), 5'd16, 1);
    send(MODE_DATA, rnd64(), rnd64(), 5'd16, 1);
    setup(rnd64(), rnd64(), rnd64(), rnd64(), 2'd1, 5'd31);
    send(MODE_START, '1, '1, 5'd16, 0);
    send(MODE_DATA, rnd64(), rnd64(), 5'd16, 1);
    // key change after a start only applies at the next start
    drain();
    write_reg(CFG_KEY_W0, rnd64());
    send(MODE_DATA, rnd64(), rnd64(), 5'd16, 1);
    send(MODE_START, rnd64(), rnd64(), 5'd16, 1);
    setup(rnd64(), rnd64(), rnd64(), rnd64(), 2'd0, 5'd9);
    send(MODE_START, '1, '1, 5'd0, 1);
    send(MODE_DATA, rnd64(), rnd64(), 5'd16, 1);

    for (int p = 0; p < 12; p++) begin
      send_idle_pct = (p < 4) ? 10 : (p < 8) ? 64 : 0;
      stall_pct = (p < 4) ? 64 : (p < 8) ? 10 : 0;
      case (p % 4)
        0: cb = 5'd16;
        1: cb = 5'd0;
        2: cb = 5'($urandom_range(17, 31));
        default: cb = 5'($urandom_range(1, 15));
      endcase
      setup(rnd64(), rnd64(), rnd64(), rnd64(), 2'(p % 4), cb);
      send(MODE_START, rnd64(), rnd64(), rnd_count(), 1'($urandom));
      for (int n = 0; n < 60; n++) begin
        if ($urandom_range(0, 99) < 8)
          send(MODE_START, rnd64(), rnd64(), rnd_count(), 1'($urandom));
        else
          send(MODE_DATA, rnd64(), rnd64(), rnd_count(), 1'($urandom));
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("[aes_counter_mode_cipher] OK");
    else
      $display("[aes_counter_mode_cipher] ERROR");
    $finish;
  end
endmodule
